/* design/page_packed_frame_buffer_engine_macros.svh */
// assertion macros for the page packed frame buffer engine
`ifndef PAGE_PACKED_FRAME_BUFFER_ENGINE_MACROS_SVH
`define PAGE_PACKED_FRAME_BUFFER_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define PPFB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ppfb assertion failed");
// condition must never be seen at a clock edge out of reset
`define PPFB_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("ppfb forbidden condition seen");
`else
`define PPFB_ASSERT(name, prop)
`define PPFB_NEVER(name, cond)
`endif
`endif

/* design/ppfb_pkg.sv */
// shared constants and payload types of the page packed frame buffer engine
`timescale 1ns / 1ps
`default_nettype none
package ppfb_pkg;

  localparam int unsigned SCREEN_WIDTH  = 128;
  localparam int unsigned SCREEN_HEIGHT = 64;
  localparam int unsigned PAGE_ROWS     = 8;
  localparam int unsigned PAGE_COUNT    = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int unsigned STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int unsigned ADDR_W        = $clog2(STORE_BYTES);
  localparam int unsigned COORD_W       = 8;
  localparam int unsigned ROW_SEL_W     = $clog2(PAGE_ROWS);
  localparam int unsigned PAGE_W        = COORD_W - ROW_SEL_W;

  localparam logic [2:0] CMD_PIXEL = 3'd0;
  localparam logic [2:0] CMD_FILL  = 3'd1;
  localparam logic [2:0] CMD_BLIT  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [COORD_W-1:0] x_a;
    logic [COORD_W-1:0] y_a;
    logic [COORD_W-1:0] x_b;
    logic [COORD_W-1:0] y_b;
    logic               pixel_on;
    logic [7:0]         bitmap_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       op_done;
  } res_t;

endpackage
`default_nettype wire

/* design/page_packed_frame_buffer_engine.sv */
// monochrome page packed frame store with pixel, rectangle, blit, clear and read commands
//
//  channel   ports                       handshake
//  command   req_i                       transfer when start_i & !busy_o
//  result    res_o                       one cycle, marked by res_strobe_o, no stall
//
// pixel and blit: store read, then write back, per byte; read: store read, then result
// blit covers one byte, or two when its top row is not page aligned; fill: one page byte
// per cycle over the covered bytes; clear zeroes every store byte; empty fill, off-screen
// pixel, unknown: no store access; the frame store has one read port and one write port
// after reset a clearing pass runs with busy_o high
// results are never held off; busy_o drops in the cycle that carries the result
`timescale 1ns / 1ps
`default_nettype none
`include "page_packed_frame_buffer_engine_macros.svh"
module page_packed_frame_buffer_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire ppfb_pkg::req_t req_i,
  output logic                busy_o,
  output logic                res_strobe_o,
  output ppfb_pkg::res_t      res_o
);

  localparam int unsigned AW    = ppfb_pkg::ADDR_W;
  localparam int unsigned CW    = ppfb_pkg::COORD_W;
  localparam int unsigned PW    = ppfb_pkg::PAGE_W;
  localparam int unsigned SW    = ppfb_pkg::ROW_SEL_W;
  localparam int unsigned FULLW = PW + CW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_CLR  = 2'd3;

  localparam logic [AW-1:0] CLR_LAST = AW'(ppfb_pkg::STORE_BYTES - 1);

  // frame store
  logic [7:0] mem [ppfb_pkg::STORE_BYTES];
  logic [7:0] ram_q;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] col_q, col_d, x0_q, x0_d, x1_q, x1_d;
  logic [CW-1:0] y0_q, y0_d, y1_q, y1_d;
  logic [PW-1:0] pg_q, pg_d, p1_q, p1_d;
  logic [SW-1:0] s_q, s_d;
  logic [7:0]    data_q, data_d;
  logic          on_q, on_d, blit_q, blit_d, first_q, first_d, rd_ok_q, rd_ok_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          clr_rep_q, clr_rep_d;
  logic          fin_q, fin_d, fin_rd_q, fin_rd_d, fin_ok_q, fin_ok_d;
  logic          w_en_q, w_en_d;
  logic [AW-1:0] w_addr_q, w_addr_d;
  logic [7:0]    w_mask_q, w_mask_d, w_val_q, w_val_d;

  // byte issue from walker registers
  logic [FULLW-1:0] iss_full;
  logic [AW-1:0]    iss_addr;
  logic             iss_in;
  logic [7:0]       row_ok, fmask, iss_mask, iss_val;
  logic [15:0]      bval_w, bmask_w;
  logic             last_byte;

  // command decode
  logic [CW-1:0] xb_sel, yb_sel, lo_x, hi_x, lo_y, hi_y, hi_xc, hi_yc;
  logic          rect_empty;
  logic [CW-1:0] px, r0;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  always_comb begin
    iss_full = FULLW'(pg_q) * FULLW'(ppfb_pkg::SCREEN_WIDTH) + FULLW'(col_q);
    iss_in   = (32'(col_q) < ppfb_pkg::SCREEN_WIDTH) && (32'(pg_q) < ppfb_pkg::PAGE_COUNT);
    iss_addr = iss_in ? iss_full[AW-1:0] : '0;
    for (int i = 0; i < 8; i++) begin
      row_ok[i] = 32'({pg_q, SW'(i)}) < ppfb_pkg::SCREEN_HEIGHT;
      fmask[i]  = ({pg_q, SW'(i)} >= y0_q) && ({pg_q, SW'(i)} <= y1_q);
    end
    // blit byte straddles two pages when its top row is not page aligned
    bval_w   = 16'({8'h00, data_q} << s_q);
    bmask_w  = 16'(16'h00ff << s_q);
    iss_mask = (blit_q ? (first_q ? bmask_w[7:0] : bmask_w[15:8]) : fmask)
               & row_ok & {8{iss_in}};
    iss_val  = blit_q ? (first_q ? bval_w[7:0] : bval_w[15:8]) : {8{on_q}};
    last_byte = (col_q == x1_q) && (pg_q == p1_q);
  end

  always_comb begin
    xb_sel = (req_i.cmd == ppfb_pkg::CMD_PIXEL) ? req_i.x_a : req_i.x_b;
    yb_sel = (req_i.cmd == ppfb_pkg::CMD_PIXEL) ? req_i.y_a : req_i.y_b;
    lo_x   = (req_i.x_a < xb_sel) ? req_i.x_a : xb_sel;
    hi_x   = (req_i.x_a < xb_sel) ? xb_sel : req_i.x_a;
    lo_y   = (req_i.y_a < yb_sel) ? req_i.y_a : yb_sel;
    hi_y   = (req_i.y_a < yb_sel) ? yb_sel : req_i.y_a;
    hi_xc  = (32'(hi_x) >= ppfb_pkg::SCREEN_WIDTH) ? CW'(ppfb_pkg::SCREEN_WIDTH - 1) : hi_x;
    hi_yc  = (32'(hi_y) >= ppfb_pkg::SCREEN_HEIGHT) ? CW'(ppfb_pkg::SCREEN_HEIGHT - 1) : hi_y;
    rect_empty = (lo_x > hi_xc) || (lo_y > hi_yc);
    px     = CW'(req_i.x_a + req_i.x_b);
    r0     = CW'(req_i.y_a + {req_i.y_b[PW-1:0], SW'(0)});
  end

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    x0_d      = x0_q;
    x1_d      = x1_q;
    y0_d      = y0_q;
    y1_d      = y1_q;
    pg_d      = pg_q;
    p1_d      = p1_q;
    s_d       = s_q;
    data_d    = data_q;
    on_d      = on_q;
    blit_d    = blit_q;
    first_d   = first_q;
    rd_ok_d   = rd_ok_q;
    clr_d     = clr_q;
    clr_rep_d = clr_rep_q;
    fin_d     = 1'b0;
    fin_rd_d  = 1'b0;
    fin_ok_d  = 1'b0;
    w_en_d    = 1'b0;
    w_addr_d  = iss_addr;
    w_mask_d  = iss_mask;
    w_val_d   = iss_val;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (req_i.cmd)
            ppfb_pkg::CMD_PIXEL, ppfb_pkg::CMD_FILL: begin
              if (rect_empty) begin
                fin_d    = 1'b1;
                fin_ok_d = 1'b1;
              end else begin
                state_d = ST_WALK;
                col_d   = lo_x;
                x0_d    = lo_x;
                x1_d    = hi_xc;
                y0_d    = lo_y;
                y1_d    = hi_yc;
                pg_d    = lo_y[CW-1:SW];
                p1_d    = hi_yc[CW-1:SW];
                on_d    = req_i.pixel_on;
                blit_d  = 1'b0;
              end
            end
            ppfb_pkg::CMD_BLIT: begin
              state_d = ST_WALK;
              col_d   = px;
              x0_d    = px;
              x1_d    = px;
              pg_d    = r0[CW-1:SW];
              p1_d    = (r0[SW-1:0] != '0) ? PW'(r0[CW-1:SW] + 1'b1) : r0[CW-1:SW];
              s_d     = r0[SW-1:0];
              data_d  = req_i.bitmap_byte;
              blit_d  = 1'b1;
              first_d = 1'b1;
            end
            ppfb_pkg::CMD_CLEAR: begin
              state_d   = ST_CLR;
              clr_d     = '0;
              clr_rep_d = 1'b1;
            end
            ppfb_pkg::CMD_READ: begin
              state_d = ST_RD;
              col_d   = req_i.x_a;
              pg_d    = req_i.y_a[PW-1:0];
              rd_ok_d = (32'(req_i.x_a) < ppfb_pkg::SCREEN_WIDTH)
                        && (32'(req_i.y_a) < ppfb_pkg::PAGE_COUNT);
            end
            default: begin
              fin_d = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        w_en_d  = iss_mask != '0;
        first_d = 1'b0;
        if (last_byte) begin
          state_d  = ST_IDLE;
          fin_d    = 1'b1;
          fin_ok_d = 1'b1;
        end else if (col_q == x1_q) begin
          col_d = x0_q;
          pg_d  = PW'(pg_q + 1'b1);
        end else begin
          col_d = CW'(col_q + 1'b1);
        end
      end
      ST_RD: begin
        state_d  = ST_IDLE;
        fin_d    = 1'b1;
        fin_ok_d = 1'b1;
        fin_rd_d = rd_ok_q;
      end
      ST_CLR: begin
        if (clr_q == CLR_LAST) begin
          state_d  = ST_IDLE;
          fin_d    = clr_rep_q;
          fin_ok_d = clr_rep_q;
        end else begin
          clr_d = AW'(clr_q + 1'b1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_q     <= '0;
      clr_rep_q <= 1'b0;
      fin_q     <= 1'b0;
      fin_rd_q  <= 1'b0;
      fin_ok_q  <= 1'b0;
      w_en_q    <= 1'b0;
      first_q   <= 1'b0;
      blit_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      clr_rep_q <= clr_rep_d;
      fin_q     <= fin_d;
      fin_rd_q  <= fin_rd_d;
      fin_ok_q  <= fin_ok_d;
      w_en_q    <= w_en_d;
      first_q   <= first_d;
      blit_q    <= blit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q    <= col_d;
    x0_q     <= x0_d;
    x1_q     <= x1_d;
    y0_q     <= y0_d;
    y1_q     <= y1_d;
    pg_q     <= pg_d;
    p1_q     <= p1_d;
    s_q      <= s_d;
    data_q   <= data_d;
    on_q     <= on_d;
    rd_ok_q  <= rd_ok_d;
    w_addr_q <= w_addr_d;
    w_mask_q <= w_mask_d;
    w_val_q  <= w_val_d;
  end

  // write back merges the masked bits into the byte read in the cycle before
  always_comb begin
    mem_we    = (state_q == ST_CLR) || w_en_q;
    mem_waddr = (state_q == ST_CLR) ? clr_q : w_addr_q;
    mem_wdata = (state_q == ST_CLR) ? 8'h00 : ((ram_q & ~w_mask_q) | (w_val_q & w_mask_q));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    ram_q <= mem[iss_addr];
  end

  assign busy_o          = state_q != ST_IDLE;
  assign res_strobe_o    = fin_q;
  assign res_o.read_data = fin_rd_q ? ram_q : 8'h00;
  assign res_o.op_done   = fin_ok_q;

  `PPFB_NEVER(a_no_rmw_during_clear, w_en_q && (state_q == ST_CLR))
  `PPFB_ASSERT(a_rmw_follows_walk, w_en_q |-> ($past(state_q) == ST_WALK))
  `PPFB_ASSERT(a_result_when_idle, res_strobe_o |-> (state_q == ST_IDLE))
  `PPFB_ASSERT(a_read_data_only_done, (res_strobe_o && (res_o.read_data != 8'h00)) |-> res_o.op_done)

endmodule
`default_nettype wire
